// ===== hw/rtl/bitmap_first_free_allocator_assert.svh =====
// assertion macros for the first-free allocator
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_ASSERT_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_ASSERT_SVH

// a property that must hold at every clock edge outside reset
`define BFFA_ASSERT(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("bffa check failed");

// a condition that must be followed by another in the next cycle
`define BFFA_ASSERT_NEXT(label, cond, nxt) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error("bffa sequence check failed");

`endif

// ===== hw/rtl/bffa_pkg.sv =====
package bffa_pkg;

	localparam int BYTE_W   = 8;
	localparam int IN_IDX_W = 12;
	localparam int IDX_W    = 15;
	localparam int CFG_W    = 4;

	localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hFF;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_LOAD  = 1'b1;

	typedef logic [BYTE_W-1:0] map_byte_t;
	typedef logic [2:0]        bit_sel_t;

	// lowest clear bit of a byte that is not full
	function automatic bit_sel_t lowest_zero(map_byte_t v);
		bit_sel_t k;
		k = 3'd7;
		for (int i = 6; i >= 0; i--) begin
			if (!v[i]) begin
				k = 3'(i);
			end
		end
		return k;
	endfunction

endpackage

// ===== hw/rtl/bffa_ram.sv =====
module bffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/bitmap_first_free_allocator.sv =====
// bitmap first-fit allocator
//
// input channel (in_valid/in_ready): func selects allocate or load. a load
// writes byte_value into map byte byte_index (ignored beyond the map). an
// allocate scans map bytes from 0 upward over sectors_in_use sectors
// (saturated at MAP_SECTORS), takes the lowest clear bit of the first byte
// that is not 0xFF, sets it and returns byte*8+bit, or raises alloc_failed.
// output channel (out_valid/out_ready): one result per transfer in, in order.
// configuration: cfg_wr_en writes cfg_wr_data into sectors_in_use (reset 1).
// the scan issues one read of the single-port-read map RAM per cycle, which
// sets the allocate time; one item is worked on at a time.
// reset: the map RAM is swept to zero, one byte a cycle, over all MAP_BYTES
// bytes (4096 by default); in_ready stays low during the sweep, config
// writes are taken as ever.
// stall: the result sits in an output register; the next item can be taken
// and worked on meanwhile, and only its finished result waits for the slot.
module bitmap_first_free_allocator #(
	parameter int SECTOR_BYTES = 512,
	parameter int MAP_SECTORS  = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_wr_en,
	input  logic [bffa_pkg::CFG_W-1:0]    cfg_wr_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [bffa_pkg::IN_IDX_W-1:0] byte_index,
	input  logic [bffa_pkg::BYTE_W-1:0]   byte_value,
	// output channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bffa_pkg::IDX_W-1:0]    alloc_index,
	output logic                          alloc_failed
);

	localparam int MAP_BYTES = SECTOR_BYTES * MAP_SECTORS;
	localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	// counter width that can also hold MAP_BYTES itself
	localparam int CW = $clog2(MAP_BYTES + 1);
	localparam int IW = bffa_pkg::IDX_W;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t                         st_q;
	logic [CW-1:0]                  ptr_q;
	logic [CW-1:0]                  limit_q;
	logic [bffa_pkg::CFG_W-1:0]     sectors_in_use_q;
	logic                           rdv_s1;
	logic [AW-1:0]                  addr_s1;
	logic [IW-1:0]                  res_index_q;
	logic                           res_failed_q;
	logic                           out_valid_q;
	logic [IW-1:0]                  alloc_index_q;
	logic                           alloc_failed_q;

	logic                           rd_en;
	bffa_pkg::map_byte_t            rd_data;
	logic                           hit;
	bffa_pkg::bit_sel_t             hit_bit;
	logic [IW-1:0]                  hit_index;
	logic                           in_map;
	logic                           load_we;
	logic                           ram_we;
	logic [AW-1:0]                  ram_waddr;
	bffa_pkg::map_byte_t            ram_wdata;
	logic [CW-1:0]                  limit_d;

	assign in_ready = (st_q == ST_IDLE);

	// bytes searched: sectors saturated at the map size
	always_comb begin
		if (32'(sectors_in_use_q) > MAP_SECTORS) begin
			limit_d = CW'(MAP_BYTES);
		end else begin
			limit_d = CW'(32'(sectors_in_use_q) * SECTOR_BYTES);
		end
	end

	// scan: one read per cycle, data checked in the following cycle
	assign rd_en   = (st_q == ST_SCAN) && (ptr_q < limit_q);
	assign hit     = (st_q == ST_SCAN) && rdv_s1 && (rd_data != bffa_pkg::FULL_BYTE);
	assign hit_bit = bffa_pkg::lowest_zero(rd_data);
	assign hit_index = IW'({addr_s1, hit_bit});

	assign in_map  = (32'(byte_index) < MAP_BYTES);
	assign load_we = in_valid && in_ready && (func == bffa_pkg::FUNC_LOAD) && in_map;

	// write port: clearing sweep, set bit on a hit, or a map load
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(byte_index);
		ram_wdata = byte_value;
		if (st_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = ptr_q[AW-1:0];
			ram_wdata = '0;
		end else if (hit) begin
			ram_we    = 1'b1;
			ram_waddr = addr_s1;
			ram_wdata = rd_data | (bffa_pkg::map_byte_t'(1) << hit_bit);
		end else if (load_we) begin
			ram_we = 1'b1;
		end
	end

	bffa_ram #(
		.WIDTH(bffa_pkg::BYTE_W),
		.DEPTH(MAP_BYTES)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (rd_en),
		.raddr(ptr_q[AW-1:0]),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q             <= ST_CLEAR;
			ptr_q            <= '0;
			limit_q          <= '0;
			sectors_in_use_q <= bffa_pkg::CFG_W'(1);
			rdv_s1           <= 1'b0;
			addr_s1          <= '0;
			res_index_q      <= '0;
			res_failed_q     <= 1'b0;
			out_valid_q      <= 1'b0;
			alloc_index_q    <= '0;
			alloc_failed_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				sectors_in_use_q <= cfg_wr_data;
			end
			// the finish state refills the slot itself
			if (out_ready && (st_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			rdv_s1  <= rd_en && !hit;
			addr_s1 <= ptr_q[AW-1:0];
			case (st_q)
				ST_CLEAR: begin
					if (ptr_q == CW'(MAP_BYTES - 1)) begin
						ptr_q <= '0;
						st_q  <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + CW'(1);
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						if (func == bffa_pkg::FUNC_LOAD) begin
							// load result is all zero
							res_index_q  <= '0;
							res_failed_q <= 1'b0;
							st_q         <= ST_FINISH;
						end else begin
							ptr_q   <= '0;
							limit_q <= limit_d;
							st_q    <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						ptr_q <= ptr_q + CW'(1);
					end
					if (hit) begin
						res_index_q  <= hit_index;
						res_failed_q <= 1'b0;
						st_q         <= ST_FINISH;
					end else if (!rd_en) begin
						// last byte checked without a hit, or nothing to search
						res_index_q  <= '0;
						res_failed_q <= 1'b1;
						st_q         <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q    <= 1'b1;
						alloc_index_q  <= res_index_q;
						alloc_failed_q <= res_failed_q;
						st_q           <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign alloc_index  = alloc_index_q;
	assign alloc_failed = alloc_failed_q;

`include "bitmap_first_free_allocator_assert.svh"

	`BFFA_ASSERT(a_fail_index_zero, !(out_valid && alloc_failed) || (alloc_index == '0))
	`BFFA_ASSERT_NEXT(a_one_item_at_a_time, in_valid && in_ready, !in_ready)
	`BFFA_ASSERT(a_check_only_in_scan, !rdv_s1 || (st_q == ST_SCAN))

endmodule
